FILE: hdl/aarm_pkg.sv
// aarm_pkg: item types and fixed constants for the axis-angle rotation matrix block
// no dependencies; used by axis_angle_rotation_matrix, aarm_checker and the testbench
`timescale 1ns / 1ps

package aarm_pkg;

	// fraction bits of the axis length out of the square root
	localparam int LEN_FRAC = 15;
	// squared length: three 16-bit squares summed
	localparam int L2_W     = 32;
	// radicand is the squared length shifted up by twice the length fraction
	localparam int X_W      = L2_W + 2 * LEN_FRAC;
	// root bits, one per square-root step
	localparam int ROOT_W   = X_W / 2;
	// partial remainder of the square root
	localparam int REM_W    = ROOT_W + 2;
	// number of distinct entries of the symmetric product u*u^T
	localparam int NPAIR    = 6;

	// pair order: xx, yy, zz, xy, xz, yz
	localparam logic [1:0] PAIR_I [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] PAIR_J [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] sine;
		logic signed [15:0] cosine;
	} req_t;

	typedef struct packed {
		logic signed [15:0] m_r0_c0;
		logic signed [15:0] m_r1_c0;
		logic signed [15:0] m_r2_c0;
		logic signed [15:0] m_r0_c1;
		logic signed [15:0] m_r1_c1;
		logic signed [15:0] m_r2_c1;
		logic signed [15:0] m_r0_c2;
		logic signed [15:0] m_r1_c2;
		logic signed [15:0] m_r2_c2;
		logic               axis_zero;
	} rsp_t;

	// what rides along the square root and divide stages
	typedef struct packed {
		logic [2:0][15:0]   axis;
		logic signed [15:0] sine;
		logic signed [15:0] cosine;
		logic               zero;
	} side_t;

endpackage

FILE: hdl/axis_angle_rotation_matrix.sv
// axis_angle_rotation_matrix: pipelined axis-angle (Rodrigues) rotation matrix
// depends on aarm_pkg for item types and constants
`timescale 1ns / 1ps

// Takes one item per clock while the skid entry is empty: an integer
// rotation axis of any length plus the sine and cosine of the angle in
// signed fixed point with FRAC_BITS fraction bits, and returns the nine
// entries of R = c*I + s*[u]x + (1-c)*u*u^T in the same format, saturated
// to 16 bits. The axis is normalized through a bit-per-stage square root
// (31 stages) and three bit-per-stage dividers (FRAC_BITS+1 stages),
// followed by three multiply stages. Throughput is one item per cycle
// while the skid entry is empty, set by the fully pipelined square root
// and divider chains. A zero axis returns the identity matrix with
// axis_zero set. A two-entry output buffer (output register plus skid)
// lets the pipeline keep taking items after rsp_ready drops, until the skid
// entry fills; req_ready depends only on registered state.
module axis_angle_rotation_matrix #(
	parameter int FRAC_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  aarm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output aarm_pkg::rsp_t rsp
);

	localparam int ROOT_W = aarm_pkg::ROOT_W;
	localparam int REM_W  = aarm_pkg::REM_W;
	localparam int L2_W   = aarm_pkg::L2_W;
	localparam int X_W    = aarm_pkg::X_W;
	// quotient bits: unit components never exceed 1.0
	localparam int QB     = FRAC_BITS + 1;
	// dividend: 17-bit magnitude shifted up, plus half the divisor
	localparam int NW     = FRAC_BITS + aarm_pkg::LEN_FRAC + 17;
	localparam int DR_W   = NW - QB;
	localparam int UW     = FRAC_BITS + 2;
	localparam int PW     = 2 * UW;
	localparam int MCW    = ((UW > 17) ? UW : 17) + 1;
	localparam int TW     = UW + 16;
	localparam int QW     = UW + MCW;
	localparam int SW     = QW + 2;

	localparam logic signed [MCW-1:0] ONE_MC = MCW'(1) <<< FRAC_BITS;
	localparam logic signed [PW:0]    HALF_P = (PW + 1)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [TW:0]    HALF_T = (TW + 1)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QW:0]    HALF_Q = (QW + 1)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SW-1:0]  SAT_HI = SW'(32767);
	localparam logic signed [SW-1:0]  SAT_LO = -SW'(32768);
	// identity diagonal, 1.0 saturated to the 16-bit field
	localparam logic [15:0] ONE_SAT = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

	// pipeline advances unless the skid entry is occupied
	logic en;
	logic skid_v_q;
	assign en        = !skid_v_q;
	assign req_ready = en;

	// stage 1: capture and square the axis components
	logic                      v_s1;
	aarm_pkg::side_t           side_s1;
	logic [L2_W-2:0]           sq_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.axis[0] <= req.axis_x;
			side_s1.axis[1] <= req.axis_y;
			side_s1.axis[2] <= req.axis_z;
			side_s1.sine    <= req.sine;
			side_s1.cosine  <= req.cosine;
			side_s1.zero    <= (req.axis_x == 16'sd0) && (req.axis_y == 16'sd0) &&
				(req.axis_z == 16'sd0);
			sq_s1[0] <= (L2_W - 1)'(req.axis_x * req.axis_x);
			sq_s1[1] <= (L2_W - 1)'(req.axis_y * req.axis_y);
			sq_s1[2] <= (L2_W - 1)'(req.axis_z * req.axis_z);
		end
	end

	// stage 2 feeds the square root chain: squared length
	logic                 rt_v_s    [0:ROOT_W];
	logic [L2_W-1:0]      rt_l2_s   [0:ROOT_W];
	aarm_pkg::side_t      rt_side_s [0:ROOT_W];
	logic [REM_W-1:0]     rt_rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]    rt_root_s [1:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_l2_s[0]   <= L2_W'(sq_s1[0]) + L2_W'(sq_s1[1]) + L2_W'(sq_s1[2]);
			rt_side_s[0] <= side_s1;
		end
	end

	// square root, one root bit per stage, msb first
	genvar j;
	generate
		for (j = 0; j < ROOT_W; j++) begin : g_sqrt
			logic [X_W-1:0]     x;
			logic [1:0]         pair;
			logic [REM_W-1:0]   rem_in;
			logic [ROOT_W-1:0]  root_in;
			logic [REM_W+1:0]   cur;
			logic [REM_W+1:0]   trial;
			logic               ge;
			logic [REM_W+1:0]   diff;

			assign x    = {rt_l2_s[j], {(2 * aarm_pkg::LEN_FRAC){1'b0}}};
			assign pair = x[X_W-1-2*j -: 2];
			if (j == 0) begin : g_first
				assign rem_in  = '0;
				assign root_in = '0;
			end else begin : g_rest
				assign rem_in  = rt_rem_s[j];
				assign root_in = rt_root_s[j];
			end
			assign cur   = {rem_in, pair};
			assign trial = {1'b0, root_in, 2'b01};
			assign ge    = (cur >= trial);
			assign diff  = cur - trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rt_v_s[j+1] <= 1'b0;
				end else if (en) begin
					rt_v_s[j+1] <= rt_v_s[j];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rt_rem_s[j+1]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
					rt_root_s[j+1] <= {root_in[ROOT_W-2:0], ge};
					rt_l2_s[j+1]   <= rt_l2_s[j];
					rt_side_s[j+1] <= rt_side_s[j];
				end
			end
		end
	endgenerate

	// divide setup: dividend = |a| << (FRAC_BITS+15) plus half the length
	logic                 dv_v_s    [0:QB];
	aarm_pkg::side_t      dv_side_s [0:QB];
	logic [ROOT_W-1:0]    dv_d_s    [0:QB];
	logic [DR_W-1:0]      dv_r_s    [0:QB][3];
	logic [QB-1:0]        dv_nlo_s  [0:QB][3];
	logic [QB-1:0]        dv_q_s    [0:QB][3];
	logic [16:0]          mag       [3];
	logic [NW-1:0]        num       [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = rt_side_s[ROOT_W].axis[i][15] ?
				(17'd0 - {1'b1, rt_side_s[ROOT_W].axis[i]}) :
				{1'b0, rt_side_s[ROOT_W].axis[i]};
			num[i] = (NW'(mag[i]) << (FRAC_BITS + aarm_pkg::LEN_FRAC)) +
				NW'(rt_root_s[ROOT_W] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= rt_v_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s[0] <= rt_side_s[ROOT_W];
			dv_d_s[0]    <= rt_root_s[ROOT_W];
			for (int i = 0; i < 3; i++) begin
				dv_r_s[0][i]   <= num[i][NW-1:QB];
				dv_nlo_s[0][i] <= num[i][QB-1:0];
				dv_q_s[0][i]   <= '0;
			end
		end
	end

	// restoring dividers, one quotient bit per stage for all three components
	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_div
			logic [DR_W:0]   cur  [3];
			logic            ge   [3];
			logic [DR_W:0]   diff [3];

			always_comb begin
				for (int i = 0; i < 3; i++) begin
					cur[i]  = {dv_r_s[k][i], dv_nlo_s[k][i][QB-1-k]};
					ge[i]   = (cur[i] >= (DR_W + 1)'(dv_d_s[k]));
					diff[i] = cur[i] - (DR_W + 1)'(dv_d_s[k]);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[k+1] <= 1'b0;
				end else if (en) begin
					dv_v_s[k+1] <= dv_v_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_side_s[k+1] <= dv_side_s[k];
					dv_d_s[k+1]    <= dv_d_s[k];
					for (int i = 0; i < 3; i++) begin
						dv_r_s[k+1][i]   <= ge[i] ? diff[i][DR_W-1:0] : cur[i][DR_W-1:0];
						dv_nlo_s[k+1][i] <= dv_nlo_s[k][i];
						dv_q_s[k+1][i]   <= {dv_q_s[k][i][QB-2:0], ge[i]};
					end
				end
			end
		end
	endgenerate

	// m1: signed unit axis, products u_i*u_j and u_k*sine, 1 - cosine
	logic signed [UW-1:0]  u [3];
	logic                  v_m1;
	logic                  zero_m1;
	logic signed [15:0]    cos_m1;
	logic signed [MCW-1:0] mc_m1;
	logic signed [PW-1:0]  p_m1 [aarm_pkg::NPAIR];
	logic signed [TW-1:0]  t_m1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u[i] = dv_side_s[QB].axis[i][15] ? -$signed({1'b0, dv_q_s[QB][i]}) :
				$signed({1'b0, dv_q_s[QB][i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else if (en) begin
			v_m1 <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_m1 <= dv_side_s[QB].zero;
			cos_m1  <= dv_side_s[QB].cosine;
			mc_m1   <= ONE_MC - MCW'(dv_side_s[QB].cosine);
			for (int n = 0; n < aarm_pkg::NPAIR; n++) begin
				p_m1[n] <= u[aarm_pkg::PAIR_I[n]] * u[aarm_pkg::PAIR_J[n]];
			end
			for (int i = 0; i < 3; i++) begin
				t_m1[i] <= u[i] * dv_side_s[QB].sine;
			end
		end
	end

	// m2: round the products, scale the pair terms by 1 - cosine
	logic signed [PW:0]    p_rnd  [aarm_pkg::NPAIR];
	logic signed [TW:0]    t_rnd  [3];
	logic                  v_m2;
	logic                  zero_m2;
	logic signed [15:0]    cos_m2;
	logic signed [QW-1:0]  qp_m2  [aarm_pkg::NPAIR];
	logic signed [TW-1:0]  t_m2   [3];

	always_comb begin
		for (int n = 0; n < aarm_pkg::NPAIR; n++) begin
			p_rnd[n] = ((PW + 1)'(p_m1[n]) + HALF_P) >>> FRAC_BITS;
		end
		for (int i = 0; i < 3; i++) begin
			t_rnd[i] = ((TW + 1)'(t_m1[i]) + HALF_T) >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_m2 <= zero_m1;
			cos_m2  <= cos_m1;
			for (int n = 0; n < aarm_pkg::NPAIR; n++) begin
				qp_m2[n] <= $signed(p_rnd[n][UW-1:0]) * mc_m1;
			end
			for (int i = 0; i < 3; i++) begin
				t_m2[i] <= t_rnd[i][TW-1:0];
			end
		end
	end

	// m3: round, assemble entries, saturate, identity on a zero axis
	logic signed [QW:0]    q_rnd [aarm_pkg::NPAIR];
	logic signed [SW-1:0]  q_w   [aarm_pkg::NPAIR];
	logic signed [SW-1:0]  t_w   [3];
	logic signed [SW-1:0]  c_w;
	logic signed [SW-1:0]  ent   [9];
	logic [15:0]           ent_sat [9];
	aarm_pkg::rsp_t        res;
	logic                  v_m3;
	aarm_pkg::rsp_t        res_m3;

	always_comb begin
		for (int n = 0; n < aarm_pkg::NPAIR; n++) begin
			q_rnd[n] = ((QW + 1)'(qp_m2[n]) + HALF_Q) >>> FRAC_BITS;
			q_w[n]   = SW'(q_rnd[n]);
		end
		for (int i = 0; i < 3; i++) begin
			t_w[i] = SW'(t_m2[i]);
		end
		c_w = SW'(cos_m2);
		// column-major: r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2
		ent[0] = c_w + q_w[0];
		ent[1] = q_w[3] + t_w[2];
		ent[2] = q_w[4] - t_w[1];
		ent[3] = q_w[3] - t_w[2];
		ent[4] = c_w + q_w[1];
		ent[5] = q_w[5] + t_w[0];
		ent[6] = q_w[4] + t_w[1];
		ent[7] = q_w[5] - t_w[0];
		ent[8] = c_w + q_w[2];
		for (int e = 0; e < 9; e++) begin
			if (ent[e] > SAT_HI) begin
				ent_sat[e] = 16'h7fff;
			end else if (ent[e] < SAT_LO) begin
				ent_sat[e] = 16'h8000;
			end else begin
				ent_sat[e] = ent[e][15:0];
			end
		end
		if (zero_m2) begin
			res = '0;
			res.m_r0_c0 = ONE_SAT;
			res.m_r1_c1 = ONE_SAT;
			res.m_r2_c2 = ONE_SAT;
			res.axis_zero = 1'b1;
		end else begin
			res.m_r0_c0   = ent_sat[0];
			res.m_r1_c0   = ent_sat[1];
			res.m_r2_c0   = ent_sat[2];
			res.m_r0_c1   = ent_sat[3];
			res.m_r1_c1   = ent_sat[4];
			res.m_r2_c1   = ent_sat[5];
			res.m_r0_c2   = ent_sat[6];
			res.m_r1_c2   = ent_sat[7];
			res.m_r2_c2   = ent_sat[8];
			res.axis_zero = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m3 <= 1'b0;
		end else if (en) begin
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_m3 <= res;
		end
	end

	// output register plus skid entry
	logic           out_v_q;
	aarm_pkg::rsp_t out_q;
	aarm_pkg::rsp_t skid_q;
	logic           out_free;

	assign out_free = !out_v_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (v_m3) begin
			if (out_free) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_free) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (v_m3) begin
			if (out_free) begin
				out_q <= res_m3;
			end else begin
				skid_q <= res_m3;
			end
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule

FILE: hdl/aarm_checker.sv
// aarm_checker: port-level checks for axis_angle_rotation_matrix, with its bind
// depends on aarm_pkg for the response type
`timescale 1ns / 1ps

module aarm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input aarm_pkg::rsp_t rsp
);

	// a stalled item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// back-pressure on req only follows a stalled response
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> $past(rsp_valid && !rsp_ready))
		else $error("req_ready low without a stalled response");

	// zero axis gives zero off-diagonal entries
	a_zero_offdiag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.axis_zero |->
		rsp.m_r1_c0 == 16'sd0 && rsp.m_r2_c0 == 16'sd0 && rsp.m_r0_c1 == 16'sd0 &&
		rsp.m_r2_c1 == 16'sd0 && rsp.m_r0_c2 == 16'sd0 && rsp.m_r1_c2 == 16'sd0)
		else $error("zero axis with nonzero off-diagonal");

	// zero axis gives an equal positive diagonal
	a_zero_diag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.axis_zero |->
		rsp.m_r0_c0 == rsp.m_r1_c1 && rsp.m_r1_c1 == rsp.m_r2_c2 && rsp.m_r0_c0 > 16'sd0)
		else $error("zero axis with bad diagonal");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

FILE: tb/sv/testbench.sv
// testbench: checks axis_angle_rotation_matrix against a bit-exact predictor
// depends on aarm_pkg and the axis_angle_rotation_matrix rtl
`timescale 1ns / 1ps

module testbench;

	localparam int FRAC     = 14;
	localparam int LATENCY  = FRAC + 39;
	localparam int WD_LIMIT = 20000;
	localparam int N_RAND   = 1830;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	aarm_pkg::req_t req = '0;
	logic req_ready;
	logic rsp_valid;
	aarm_pkg::rsp_t rsp;

	// matrices still owed by the block, oldest first
	aarm_pkg::rsp_t pending_mats[$];
	int   n_errors = 0;
	int   idle_cycles = 0;
	// percent of cycles each side holds off
	int   send_idle_pct = 33;
	int   recv_idle_pct = 73;

	always #6 clk = ~clk;

	axis_angle_rotation_matrix #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// rounding drop of the fraction bits, half up
	function automatic longint drop_frac(longint v);
		longint half;
		half = longint'(1) << (FRAC - 1);
		if (v >= 0) begin
			return (v + half) >>> FRAC;
		end
		return -(((-v) + half - 1) >>> FRAC);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) begin
			return 16'sd32767;
		end
		if (v < -32768) begin
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	// integer square root, bit by bit
	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) begin
			b = b >> 2;
		end
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// axis component scaled to unit length, rounded to nearest away from zero
	function automatic longint unit_axis(longint a, longint unsigned len);
		longint unsigned mag;
		longint unsigned q;
		mag = (a < 0) ? longint'(-a) : longint'(a);
		q = ((mag << (FRAC + aarm_pkg::LEN_FRAC)) + (len >> 1)) / len;
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic aarm_pkg::rsp_t rotation_matrix(aarm_pkg::req_t r);
		aarm_pkg::rsp_t m;
		longint ax, ay, az, s, c, one, mc;
		longint unsigned l2, len;
		longint ux, uy, uz, qxx, qyy, qzz, qxy, qxz, qyz, tx, ty, tz;
		ax = r.axis_x;
		ay = r.axis_y;
		az = r.axis_z;
		s = r.sine;
		c = r.cosine;
		one = longint'(1) << FRAC;
		m = '0;
		if (ax == 0 && ay == 0 && az == 0) begin
			m.m_r0_c0 = clamp16(one);
			m.m_r1_c1 = clamp16(one);
			m.m_r2_c2 = clamp16(one);
			m.axis_zero = 1'b1;
			return m;
		end
		l2 = ax * ax + ay * ay + az * az;
		len = root64(l2 << (2 * aarm_pkg::LEN_FRAC));
		ux = unit_axis(ax, len);
		uy = unit_axis(ay, len);
		uz = unit_axis(az, len);
		mc = one - c;
		qxx = drop_frac(drop_frac(ux * ux) * mc);
		qyy = drop_frac(drop_frac(uy * uy) * mc);
		qzz = drop_frac(drop_frac(uz * uz) * mc);
		qxy = drop_frac(drop_frac(ux * uy) * mc);
		qxz = drop_frac(drop_frac(ux * uz) * mc);
		qyz = drop_frac(drop_frac(uy * uz) * mc);
		tx = drop_frac(ux * s);
		ty = drop_frac(uy * s);
		tz = drop_frac(uz * s);
		m.m_r0_c0 = clamp16(c + qxx);
		m.m_r1_c0 = clamp16(qxy + tz);
		m.m_r2_c0 = clamp16(qxz - ty);
		m.m_r0_c1 = clamp16(qxy - tz);
		m.m_r1_c1 = clamp16(c + qyy);
		m.m_r2_c1 = clamp16(qyz + tx);
		m.m_r0_c2 = clamp16(qxz + ty);
		m.m_r1_c2 = clamp16(qyz - tx);
		m.m_r2_c2 = clamp16(c + qzz);
		m.axis_zero = 1'b0;
		return m;
	endfunction

	task automatic report(string what, aarm_pkg::rsp_t got, aarm_pkg::rsp_t want);
		$display("mismatch %s: got %h want %h", what, got, want);
		n_errors++;
	endtask

	// result side: random stall, compare every accepted item field by field
	always @(posedge clk) begin
		aarm_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_mats.size() == 0) begin
					report("unexpected item", rsp, '0);
				end else begin
					want = pending_mats.pop_front();
					if (rsp.m_r0_c0 !== want.m_r0_c0) report("r0c0", rsp, want);
					if (rsp.m_r1_c0 !== want.m_r1_c0) report("r1c0", rsp, want);
					if (rsp.m_r2_c0 !== want.m_r2_c0) report("r2c0", rsp, want);
					if (rsp.m_r0_c1 !== want.m_r0_c1) report("r0c1", rsp, want);
					if (rsp.m_r1_c1 !== want.m_r1_c1) report("r1c1", rsp, want);
					if (rsp.m_r2_c1 !== want.m_r2_c1) report("r2c1", rsp, want);
					if (rsp.m_r0_c2 !== want.m_r0_c2) report("r0c2", rsp, want);
					if (rsp.m_r1_c2 !== want.m_r1_c2) report("r1c2", rsp, want);
					if (rsp.m_r2_c2 !== want.m_r2_c2) report("r2c2", rsp, want);
					if (rsp.axis_zero !== want.axis_zero) report("axis_zero", rsp, want);
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WD_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// send one item; valid stays up until accepted, drops only while idling
	task automatic send_item(aarm_pkg::req_t r, bit check_typed, aarm_pkg::rsp_t typed);
		bit idle;
		idle = ($urandom_range(99) < send_idle_pct);
		if (idle) begin
			req_valid <= 1'b0;
		end
		while (idle) begin
			@(posedge clk);
			idle = ($urandom_range(99) < send_idle_pct);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		// expectation queued at the edge the item is taken
		pending_mats.push_back(check_typed ? typed : rotation_matrix(r));
	endtask

	// directed rows: typed expectation where it is read off at a glance
	typedef struct {
		aarm_pkg::req_t r;
		bit             typed_ok;
		aarm_pkg::rsp_t typed;
	} stim_row_t;

	function automatic aarm_pkg::req_t mk(int x, int y, int z, int s, int c);
		aarm_pkg::req_t r;
		r.axis_x = 16'(x);
		r.axis_y = 16'(y);
		r.axis_z = 16'(z);
		r.sine = 16'(s);
		r.cosine = 16'(c);
		return r;
	endfunction

	function automatic aarm_pkg::rsp_t ident();
		aarm_pkg::rsp_t m;
		m = '0;
		m.m_r0_c0 = 16'sd16384;
		m.m_r1_c1 = 16'sd16384;
		m.m_r2_c2 = 16'sd16384;
		m.axis_zero = 1'b1;
		return m;
	endfunction

	function automatic aarm_pkg::req_t rand_req();
		aarm_pkg::req_t r;
		int k;
		r.axis_x = 16'($urandom);
		r.axis_y = 16'($urandom);
		r.axis_z = 16'($urandom);
		r.sine = 16'($urandom);
		r.cosine = 16'($urandom);
		k = $urandom_range(9);
		// mostly in-range sine and cosine, sometimes raw 16-bit noise
		if (k < 8) begin
			r.sine = 16'($urandom_range(32768) - 16384);
			r.cosine = 16'($urandom_range(32768) - 16384);
		end
		// small axes and axes with zeroed components reach rounding corners
		if (k == 0) begin
			r.axis_x = 16'($urandom_range(6) - 3);
			r.axis_y = 16'($urandom_range(6) - 3);
			r.axis_z = 16'($urandom_range(6) - 3);
		end else if (k == 1) begin
			r.axis_y = '0;
			r.axis_z = ($urandom_range(1)) ? '0 : r.axis_z;
		end
		return r;
	endfunction

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		int i;
		row.typed_ok = 1'b1;
		row.typed = ident();
		// zero axis gives identity whatever the angle
		row.r = mk(0, 0, 0, 0, 16384);        rows.push_back(row);
		row.r = mk(0, 0, 0, -32768, 32767);   rows.push_back(row);
		row.r = mk(0, 0, 0, 16384, -16384);   rows.push_back(row);
		row.typed_ok = 1'b0;
		row.r = mk(1, 0, 0, 0, 16384);               rows.push_back(row);
		row.r = mk(0, 32767, 0, 16384, 0);           rows.push_back(row);
		row.r = mk(0, 0, -32768, -16384, 0);         rows.push_back(row);
		row.r = mk(-32768, -32768, -32768, 16384, -16384); rows.push_back(row);
		row.r = mk(32767, 32767, 32767, -16384, 16384);    rows.push_back(row);
		row.r = mk(32767, -32768, 1, 11585, 11585);  rows.push_back(row);
		row.r = mk(-1, 1, -1, 32767, -32768);        rows.push_back(row);
		row.r = mk(3, 4, 0, -32768, 32767);          rows.push_back(row);
		row.r = mk(1, 1, 1, 0, -16384);              rows.push_back(row);
		row.r = mk(-32768, 0, 0, 32767, 32767);      rows.push_back(row);
		row.r = mk(21845, -10922, 5461, -21846, 10922); rows.push_back(row);
		row.r = mk(-21846, 10921, -5462, 21845, -10923); rows.push_back(row);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[j]) begin
			send_item(rows[j].r, rows[j].typed_ok, rows[j].typed);
		end
		// hold off until the pipe has drained
		req_valid <= 1'b0;
		wait (pending_mats.size() == 0);
		@(posedge clk);

		for (i = 0; i < N_RAND; i++) begin
			if (i == N_RAND / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 33;
			end else if (i == 2 * N_RAND / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_item(rand_req(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		wait (pending_mats.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0 && pending_mats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: axis_angle_rotation_matrix.f
hdl/aarm_pkg.sv
hdl/axis_angle_rotation_matrix.sv
hdl/aarm_checker.sv
tb/sv/testbench.sv
